// File: hdl/tcw_pkg.sv
// Package for the text console writer: transaction payload types, item kinds,
// character codes, controller states and the controller/datapath command and status groups.
// No dependencies.
`timescale 1ns / 1ps

package tcw_pkg;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } tcw_in_t;

  typedef struct packed {
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
    logic [10:0] cursor_offset;
    logic [15:0] cell_value;
  } tcw_out_t;

  localparam logic [1:0] KIND_PUT   = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic [7:0] CHAR_BS    = 8'h08;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] BLANK_CHAR = 8'h20;
  localparam logic [7:0] ATTR_RESET = 8'h0F;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_FILL,
    ST_READ,
    ST_DONE
  } tcw_state_t;

  typedef struct packed {
    logic take;
    logic exec;
    logic fill_step;
    logic read_capture;
    logic out_load;
  } tcw_cmd_t;

  typedef struct packed {
    logic scroll;
    logic clear;
    logic read_hit;
    logic fill_last;
    logic out_free;
  } tcw_sts_t;

endpackage

// File: hdl/tcw_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/tcw_ctrl.sv
// Controller state machine of the text console writer.
// Depends on tcw_pkg for the state type and the command and status groups.
`timescale 1ns / 1ps

module tcw_ctrl
  import tcw_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  tcw_sts_t sts,
  output tcw_cmd_t cmd,
  output logic     in_stall
);

  tcw_state_t state;
  tcw_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_INIT: begin
        if (sts.fill_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (sts.scroll || sts.clear) begin
          state_next = ST_FILL;
        end else if (sts.read_hit) begin
          state_next = ST_READ;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_FILL: begin
        if (sts.fill_last) state_next = ST_DONE;
      end
      ST_READ: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      ST_INIT: begin
        cmd.fill_step = 1'b1;
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.take = in_valid;
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
      end
      ST_FILL: begin
        cmd.fill_step = 1'b1;
      end
      ST_READ: begin
        cmd.read_capture = 1'b1;
      end
      ST_DONE: begin
        cmd.out_load = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// File: hdl/tcw_datapath.sv
// Datapath of the text console writer: cursor, scroll origin, attribute, fill sweep,
// screen memory and output register.
// Depends on tcw_pkg and tcw_ram.
`timescale 1ns / 1ps

module tcw_datapath
  import tcw_pkg::*;
#(
  parameter int COLUMNS   = 80,
  parameter int ROWS      = 25,
  parameter int TAB_WIDTH = 8
) (
  input  logic     clk,
  input  logic     rst,
  input  tcw_in_t  in_data,
  input  logic     cfg_we,
  input  logic [7:0] cfg_wdata,
  input  tcw_cmd_t cmd,
  output tcw_sts_t sts,
  output logic     out_valid,
  input  logic     out_stall,
  output tcw_out_t out_data
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int NW    = $clog2(COLUMNS + TAB_WIDTH);
  localparam int RW    = $clog2(ROWS);
  localparam int RNW   = $clog2(ROWS + 1);
  localparam int RPW   = RW + 1;
  localparam int PW    = $clog2(TAB_WIDTH);

  tcw_in_t         item;
  logic [7:0]      attr;
  logic [CW-1:0]   cur_col;
  logic [RW-1:0]   cur_row;
  logic [PW-1:0]   phase;
  logic [RW-1:0]   top;
  logic [AW-1:0]   fill_addr;
  logic [AW-1:0]   fill_end;
  logic [15:0]     fill_value;
  logic [15:0]     read_value;

  logic [NW-1:0]   col_w;
  logic [RNW-1:0]  row_w;
  logic [PW-1:0]   ph_w;
  logic            print_w;
  logic            scroll_w;
  logic [CW-1:0]   col_next;
  logic [RW-1:0]   row_next;
  logic [PW-1:0]   phase_next;
  logic [RW-1:0]   top_next;
  logic            read_hit;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [15:0]     ram_wdata;
  logic [AW-1:0]   ram_raddr;
  logic [15:0]     ram_rdata;
  logic [AW-1:0]   cursor_addr;
  logic [AW-1:0]   scroll_base;

  // Logical row r lives in physical row (r + top) mod ROWS.
  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r,
                                              input logic [RW-1:0] t,
                                              input logic [CW-1:0] c);
    logic [RPW-1:0] s;
    s = {1'b0, r} + {1'b0, t};
    if (s >= RPW'(ROWS)) s = s - RPW'(ROWS);
    return AW'(s * COLUMNS) + AW'(c);
  endfunction

  // Next cursor for a put-character transaction.
  always_comb begin
    col_w   = NW'(cur_col);
    row_w   = RNW'(cur_row);
    ph_w    = phase;
    print_w = 1'b0;
    case (item.char_code)
      CHAR_BS: begin
        if (cur_col != '0) begin
          col_w = col_w - NW'(1);
          ph_w  = (phase == '0) ? PW'(TAB_WIDTH - 1) : phase - PW'(1);
        end
      end
      CHAR_TAB: begin
        col_w = col_w + NW'(TAB_WIDTH) - NW'(phase);
        ph_w  = '0;
      end
      CHAR_CR: begin
        col_w = '0;
        ph_w  = '0;
      end
      CHAR_LF: begin
        col_w = '0;
        ph_w  = '0;
        row_w = row_w + RNW'(1);
      end
      default: begin
        if (!item.char_code[7] && (item.char_code[6:5] != 2'b00)) begin
          print_w = 1'b1;
          col_w   = col_w + NW'(1);
          ph_w    = (phase == PW'(TAB_WIDTH - 1)) ? '0 : phase + PW'(1);
        end
      end
    endcase
    if (col_w >= NW'(COLUMNS)) begin
      col_w = '0;
      ph_w  = '0;
      row_w = row_w + RNW'(1);
    end
    scroll_w = (row_w >= RNW'(ROWS));
    if (scroll_w) row_w = RNW'(ROWS - 1);
    col_next   = CW'(col_w);
    row_next   = RW'(row_w);
    phase_next = ph_w;
  end

  assign top_next    = (top == RW'(ROWS - 1)) ? '0 : top + RW'(1);
  assign read_hit    = (32'(item.read_row) < ROWS) && (32'(item.read_col) < COLUMNS);
  assign cursor_addr = cell_addr(cur_row, top, cur_col);
  assign scroll_base = AW'(top * COLUMNS);

  assign sts.scroll    = (item.kind == KIND_PUT) && scroll_w;
  assign sts.clear     = (item.kind == KIND_CLEAR);
  assign sts.read_hit  = (item.kind == KIND_READ) && read_hit;
  assign sts.fill_last = (fill_addr == fill_end);
  assign sts.out_free  = !out_valid || !out_stall;

  always_comb begin
    ram_we    = cmd.fill_step;
    ram_waddr = fill_addr;
    ram_wdata = fill_value;
    if (cmd.exec && (item.kind == KIND_PUT) && print_w) begin
      ram_we    = 1'b1;
      ram_waddr = cursor_addr;
      ram_wdata = {attr, item.char_code};
    end
  end

  assign ram_raddr = cell_addr(RW'(item.read_row), top, CW'(item.read_col));

  tcw_ram #(
    .WIDTH(16),
    .DEPTH(CELLS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      attr       <= ATTR_RESET;
      cur_col    <= '0;
      cur_row    <= '0;
      phase      <= '0;
      top        <= '0;
      fill_addr  <= '0;
      fill_end   <= AW'(CELLS - 1);
      fill_value <= {ATTR_RESET, BLANK_CHAR};
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) attr <= cfg_wdata;
      if (cmd.fill_step && !sts.fill_last) fill_addr <= fill_addr + AW'(1);
      if (cmd.exec) begin
        if (item.kind == KIND_PUT) begin
          cur_col <= col_next;
          cur_row <= row_next;
          phase   <= phase_next;
          if (scroll_w) begin
            top        <= top_next;
            fill_addr  <= scroll_base;
            fill_end   <= scroll_base + AW'(COLUMNS - 1);
            fill_value <= {attr, BLANK_CHAR};
          end
        end else if (item.kind == KIND_CLEAR) begin
          cur_col    <= '0;
          cur_row    <= '0;
          phase      <= '0;
          fill_addr  <= '0;
          fill_end   <= AW'(CELLS - 1);
          fill_value <= {attr, BLANK_CHAR};
        end
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) item <= in_data;
    if (cmd.exec) read_value <= '0;
    if (cmd.read_capture) read_value <= ram_rdata;
    if (cmd.out_load) begin
      out_data.cursor_row    <= 5'(cur_row);
      out_data.cursor_col    <= 7'(cur_col);
      out_data.cursor_offset <= 11'(cur_row * COLUMNS + cur_col);
      out_data.cell_value    <= read_value;
    end
  end

endmodule

// File: hdl/text_console_writer.sv
// Top level of the text console writer: controller and datapath joined by command and status.
// Depends on tcw_pkg, tcw_ctrl, tcw_datapath (and through it tcw_ram).
//
//   Channel   Signals                    Direction  Payload
//   input     in_valid, in_stall         in / out   tcw_in_t  (kind, char_code, read_row, read_col)
//   output    out_valid, out_stall       out / in   tcw_out_t (cursor_row, cursor_col,
//                                                              cursor_offset, cell_value)
//   config    cfg_we, cfg_wdata          in         text attribute byte
//
// A put-character, unused-kind or out-of-range read transaction passes through the execute and
// done states from acceptance to the next acceptance; a read of a cell on the screen also passes
// through the read state because the screen memory read is registered.
// A character that scrolls adds a fill sweep, one memory write per cell of the blanked row,
// and a clear adds a sweep over all ROWS * COLUMNS cells, one per cell, through the single write port.
// After reset the screen memory is swept over all ROWS * COLUMNS cells (2000 by default) to set
// every cell to the blank white cell; no input transaction is taken during that sweep, while
// configuration writes are accepted as usual.
// The result sits in an output register, so a stalled output holds only the final step of the
// next transaction, never the input side of the current one.
`timescale 1ns / 1ps

module text_console_writer
  import tcw_pkg::*;
#(
  parameter int COLUMNS   = 80,
  parameter int ROWS      = 25,
  parameter int TAB_WIDTH = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  tcw_in_t    in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output tcw_out_t   out_data,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);

  tcw_cmd_t cmd;
  tcw_sts_t sts;

  // The controller sequences each transaction: take, execute, then a fill sweep or a memory
  // read where one is needed, and finally the load of the output register.
  tcw_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .sts     (sts),
    .cmd     (cmd),
    .in_stall(in_stall)
  );

  // The datapath keeps the screen as a ring of rows, so a scroll only moves the top-row origin
  // and blanks the row that becomes the new bottom one.
  tcw_datapath #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_WIDTH(TAB_WIDTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .cmd      (cmd),
    .sts      (sts),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

// File: dv/text_console_writer_test.sv
// Self-checking testbench for the text console writer, with its own screen and cursor predictor.
// Depends on tcw_pkg and text_console_writer, and needs nothing else to run.
`timescale 1ns / 1ps

module text_console_writer_test;
  import tcw_pkg::*;

  localparam int COLS      = 80;
  localparam int ROWS      = 25;
  localparam int TAB_WIDTH = 8;
  localparam int CELLS     = COLS * ROWS;

  // Highest printable byte. Everything above it is ignored.
  localparam logic [7:0] LAST_PRINTABLE = 8'h7F;
  // The fourth kind encoding has no meaning. The cursor is only reported.
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // Initial attribute for each random phase. The extremes come first.
  localparam int PHASES = 5;
  localparam int PHASE_ITEMS = 160;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int MAX_REPORTS = 40;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_stall;
  tcw_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  tcw_out_t out_data;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_wdata = '0;

  // The model keeps its own copy of the screen, the cursor and the attribute. Each
  // accepted transaction queues the cursor report that the block has to produce for it.
  class console_screen_model;
    logic [15:0] cells [0:CELLS-1];
    int unsigned row;
    int unsigned col;
    logic [7:0]  attr;
    tcw_out_t    reports_due[$];
    int unsigned errors;

    function new();
      foreach (cells[i]) cells[i] = {ATTR_RESET, BLANK_CHAR};
      row    = 0;
      col    = 0;
      attr   = ATTR_RESET;
      errors = 0;
    endfunction

    function void take_item(tcw_in_t d);
      tcw_out_t    r;
      logic [15:0] blank;
      logic [15:0] read_cell;
      blank     = {attr, BLANK_CHAR};
      read_cell = '0;
      case (d.kind)
        KIND_PUT: begin
          if (d.char_code == CHAR_BS) begin
            if (col != 0) col--;
          end else if (d.char_code == CHAR_TAB) begin
            col = (col / TAB_WIDTH + 1) * TAB_WIDTH;
          end else if (d.char_code == CHAR_CR) begin
            col = 0;
          end else if (d.char_code == CHAR_LF) begin
            col = 0;
            row++;
          end else if (d.char_code >= BLANK_CHAR && d.char_code <= LAST_PRINTABLE) begin
            cells[row * COLS + col] = {attr, d.char_code};
            col++;
          end
          if (col >= COLS) begin
            col = 0;
            row++;
          end
          // Running off the bottom shifts every row up by one and blanks the last row.
          if (row >= ROWS) begin
            for (int i = 0; i < (ROWS - 1) * COLS; i++) cells[i] = cells[i + COLS];
            for (int i = (ROWS - 1) * COLS; i < CELLS; i++) cells[i] = blank;
            row = ROWS - 1;
          end
        end
        KIND_CLEAR: begin
          foreach (cells[i]) cells[i] = blank;
          row = 0;
          col = 0;
        end
        KIND_READ: begin
          if (d.read_row < ROWS && d.read_col < COLS)
            read_cell = cells[d.read_row * COLS + d.read_col];
        end
        default: ;
      endcase
      r.cursor_row    = 5'(row);
      r.cursor_col    = 7'(col);
      r.cursor_offset = 11'(row * COLS + col);
      r.cell_value    = read_cell;
      reports_due.push_back(r);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        if (errors < MAX_REPORTS)
          $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_cursor_report(tcw_out_t got);
      tcw_out_t want;
      if (reports_due.size() == 0) begin
        if (errors < MAX_REPORTS)
          $display("%0t ns: unexpected result, expected none, actual %h", $time, got);
        errors++;
      end else begin
        want = reports_due.pop_front();
        compare_field("cursor_row", want.cursor_row, got.cursor_row);
        compare_field("cursor_col", want.cursor_col, got.cursor_col);
        compare_field("cursor_offset", want.cursor_offset, got.cursor_offset);
        compare_field("cell_value", want.cell_value, got.cell_value);
      end
    endfunction

    function int pending();
      return reports_due.size();
    endfunction
  endclass

  console_screen_model screen;

  // Tracks whether in_valid has been raised, so that it is lowered at most once in a step.
  bit          valid_held = 1'b0;
  int unsigned burst_left = 0;
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_phase = 0;

  text_console_writer #(
    .COLUMNS  (COLS),
    .ROWS     (ROWS),
    .TAB_WIDTH(TAB_WIDTH)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // The run is abandoned if it takes far longer than the slowest correct run could.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // The receiver checks every accepted result. It stalls in a pattern that moves through
  // four modes: no stalls, light random stalls, heavy random stalls, and long regular blocks.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid === 1'b1 && !out_stall) screen.check_cursor_report(out_data);
      stall_phase <= stall_phase + 1;
      case ((stall_phase >> 7) % 4)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 2) != 0);
        default: out_stall <= (stall_phase[4:3] == 2'b11);
      endcase
    end
  end

  function automatic tcw_in_t console_item(logic [1:0] k, logic [7:0] c, logic [4:0] r,
                                           logic [6:0] cl);
    tcw_in_t d;
    d.kind      = k;
    d.char_code = c;
    d.read_row  = r;
    d.read_col  = cl;
    return d;
  endfunction

  // A put transaction. The unused read fields carry random values.
  function automatic tcw_in_t put_item(logic [7:0] c);
    return console_item(KIND_PUT, c, 5'($urandom), 7'($urandom));
  endfunction

  function automatic tcw_in_t read_item(logic [4:0] r, logic [6:0] cl);
    return console_item(KIND_READ, 8'($urandom), r, cl);
  endfunction

  // Offers one transaction and holds it until it is accepted. The sender works in bursts.
  // At the end of a burst it drops valid for a random gap, which may be zero.
  task automatic send_item(input tcw_in_t d);
    int unsigned gap;
    in_data    <= d;
    in_valid   <= 1'b1;
    valid_held = 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    screen.take_item(d);
    items_sent++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = $urandom_range(0, 8);
      if (gap != 0) begin
        in_valid   <= 1'b0;
        valid_held = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // Lets the block drain completely, then idles a little longer before a register write.
  task automatic drain();
    if (valid_held) begin
      in_valid   <= 1'b0;
      valid_held = 1'b0;
    end
    while (screen.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_attribute(input logic [7:0] v);
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(posedge clk);
    screen.attr = v;
    cfg_we <= 1'b0;
  endtask

  // One stretch of random traffic. Most of it resembles real console output: short and
  // long lines of text ended by CR/LF, runs of line feeds that drive the screen into
  // scrolling, and reads of cells. The rest is raw noise and an occasional clear.
  task automatic random_run();
    int unsigned sel;
    int unsigned n;
    int unsigned pick;
    sel = $urandom_range(0, 99);
    if (sel < 45) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 100) : $urandom_range(0, 12);
      repeat (n) begin
        pick = $urandom_range(0, 19);
        if (pick == 0) send_item(put_item(CHAR_TAB));
        else if (pick == 1) send_item(put_item(CHAR_BS));
        else send_item(put_item(8'($urandom_range(BLANK_CHAR, LAST_PRINTABLE))));
      end
      pick = $urandom_range(0, 3);
      if (pick == 0) send_item(put_item(CHAR_CR));
      if (pick != 3) send_item(put_item(CHAR_LF));
    end else if (sel < 60) begin
      repeat ($urandom_range(1, 12)) send_item(put_item(CHAR_LF));
    end else if (sel < 80) begin
      repeat ($urandom_range(1, 6)) begin
        if ($urandom_range(0, 4) == 0)
          send_item(read_item(5'($urandom), 7'($urandom)));
        else
          send_item(read_item(5'($urandom_range(0, ROWS - 1)), 7'($urandom_range(0, COLS - 1))));
      end
    end else if (sel < 97) begin
      // Noise of every kind except clear, with every field random.
      repeat ($urandom_range(1, 5)) begin
        pick = $urandom_range(0, 2);
        send_item(console_item(pick == 0 ? KIND_PUT : (pick == 1 ? KIND_READ : KIND_UNUSED),
                               8'($urandom), 5'($urandom), 7'($urandom)));
      end
    end else begin
      send_item(console_item(KIND_CLEAR, 8'($urandom), 5'($urandom), 7'($urandom)));
    end
  endtask

  initial begin
    logic [7:0] phase_attr;
    int unsigned phase_end;
    screen = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part. It runs on the reset attribute and checks the reset screen contents,
    // reads out of range on each axis, the printable extremes, the ignored bytes, a
    // backspace at column 0, tab, CR, LF, the unused kind and a clear.
    send_item(read_item(5'd0, 7'd0));
    send_item(read_item(5'(ROWS - 1), 7'(COLS - 1)));
    send_item(read_item(5'h1F, 7'h7F));
    send_item(read_item(5'(ROWS), 7'd0));
    send_item(read_item(5'd0, 7'(COLS)));
    send_item(put_item(8'h41));
    send_item(put_item(BLANK_CHAR));
    send_item(put_item(LAST_PRINTABLE));
    send_item(put_item(8'h80));
    send_item(put_item(8'hFF));
    send_item(put_item(8'h00));
    send_item(put_item(8'h1F));
    repeat (4) send_item(put_item(CHAR_BS));
    send_item(put_item(CHAR_TAB));
    send_item(put_item(CHAR_TAB));
    send_item(put_item(CHAR_CR));
    send_item(put_item(CHAR_LF));
    send_item(console_item(KIND_UNUSED, 8'hFF, 5'h1F, 7'h7F));
    send_item(read_item(5'd0, 7'd0));
    send_item(console_item(KIND_CLEAR, 8'h00, 5'd0, 7'd0));
    send_item(read_item(5'd0, 7'd1));

    // Random phases, each on its own attribute. The first two use the extremes.
    for (int p = 0; p < PHASES; p++) begin
      drain();
      phase_attr = (p == 0) ? 8'h00 : (p == 1) ? 8'hFF : 8'($urandom);
      write_attribute(phase_attr);
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) random_run();
    end

    drain();
    repeat (20) @(posedge clk);
    if (screen.errors == 0 && screen.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
